// ----- hw/rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache with aging
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int unsigned ARPC_ENTRIES       = 64;
    localparam logic [31:0] ARPC_LIFETIME_RESET = 32'd300000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] ip_addr;
        logic [47:0] hw_addr;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [47:0] found_hw_addr;
        logic        was_update;
        logic        evicted;
    } t_rsp;

    // one table entry as held in the ram, stored in insertion order
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ----- hw/rtl/arpc_ram.sv -----
// ----------------------------------------------------------------------------
// arpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// sequencer that walks, compacts and shifts the entry ram
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = ARPC_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_lifetime,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_done,
    output t_rsp        o_rsp
);

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LRD  = 3'd1;
    localparam logic [2:0] ST_LEX  = 3'd2;
    localparam logic [2:0] ST_ARD  = 3'd3;
    localparam logic [2:0] ST_AEX  = 3'd4;
    localparam logic [2:0] ST_SRD  = 3'd5;
    localparam logic [2:0] ST_SEX  = 3'd6;
    localparam logic [2:0] ST_INS  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_sp, n_sp;
    logic          r_found, n_found;
    logic [47:0]   r_fmac, n_fmac;
    t_req          r_req, n_req;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [AW-1:0] raddr;
    t_entry        rdata;
    logic [CW-1:0] sp_m1;
    logic [31:0]   age;
    logic          full;

    arpc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign sp_m1 = r_sp - 1'b1;
    assign age   = r_req.now_ms - rdata.stamp;
    assign full  = (r_count == CW'(ENTRIES));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_sp    = r_sp;
        n_found = r_found;
        n_fmac  = r_fmac;
        n_req   = r_req;
        n_done  = 1'b0;
        n_rsp   = '0;
        we      = 1'b0;
        waddr   = r_wp[AW-1:0];
        wdata   = rdata;
        raddr   = r_rp[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_rp    = '0;
                    n_wp    = '0;
                    n_found = 1'b0;
                    n_state = (i_req.opcode == OP_ADD) ? ST_ARD : ST_LRD;
                end
            end
            ST_LRD: begin
                // end of table, or a hit with no gap left to close
                if (r_rp == r_count || (r_found && r_wp == r_rp)) begin
                    n_count                = r_count - (r_rp - r_wp);
                    n_done                 = 1'b1;
                    n_rsp.hit              = r_found;
                    n_rsp.found_hw_addr    = r_found ? r_fmac : '0;
                    n_state                = ST_IDLE;
                end else begin
                    n_state = ST_LEX;
                end
            end
            ST_LEX: begin
                n_rp    = r_rp + 1'b1;
                n_state = ST_LRD;
                if (r_found || age <= i_lifetime) begin
                    we   = 1'b1;
                    n_wp = r_wp + 1'b1;
                    if (!r_found && rdata.ip == r_req.ip_addr) begin
                        n_found = 1'b1;
                        n_fmac  = rdata.mac;
                    end
                end
            end
            ST_ARD: begin
                if (r_rp == r_count) begin
                    n_sp    = full ? CW'(ENTRIES - 1) : r_count;
                    n_state = ST_SRD;
                end else begin
                    n_state = ST_AEX;
                end
            end
            ST_AEX: begin
                if (rdata.ip == r_req.ip_addr) begin
                    we               = 1'b1;
                    waddr            = r_rp[AW-1:0];
                    wdata.ip         = r_req.ip_addr;
                    wdata.mac        = r_req.hw_addr;
                    wdata.stamp      = r_req.now_ms;
                    n_done           = 1'b1;
                    n_rsp.was_update = 1'b1;
                    n_state          = ST_IDLE;
                end else begin
                    n_rp    = r_rp + 1'b1;
                    n_state = ST_ARD;
                end
            end
            ST_SRD: begin
                raddr   = sp_m1[AW-1:0];
                n_state = (r_sp == '0) ? ST_INS : ST_SEX;
            end
            ST_SEX: begin
                // move entry one position older
                we      = 1'b1;
                waddr   = r_sp[AW-1:0];
                n_sp    = sp_m1;
                n_state = ST_SRD;
            end
            ST_INS: begin
                we            = 1'b1;
                waddr         = '0;
                wdata.ip      = r_req.ip_addr;
                wdata.mac     = r_req.hw_addr;
                wdata.stamp   = r_req.now_ms;
                n_count       = full ? r_count : r_count + 1'b1;
                n_done        = 1'b1;
                n_rsp.evicted = full;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_rp    <= n_rp;
        r_wp    <= n_wp;
        r_sp    <= n_sp;
        r_found <= n_found;
        r_fmac  <= n_fmac;
        r_req   <= n_req;
        r_rsp   <= n_rsp;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- hw/rtl/arp_cache_with_aging.sv -----
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// ipv4 to mac table with lazy expiry and oldest-first eviction
//
//   channel   ports                         direction  handshake
//   request   start, busy, i_req            in         start & !busy
//   response  o_done, o_rsp                 out        one-cycle strobe
//   config    psel/penable/pwrite/paddr...  in         apb, pready tied high
//
// entries sit in one ram in insertion order, newest at address 0.
// lookup walks from address 0 to the end or to a hit with no gap left to
// close; expired entries are squeezed out in the same pass. add searches
// for the address and updates a match in place, else shifts the entries
// one position older and inserts at address 0. reset clears the fill count
// only, no clearing pass. the receiver cannot stall; busy holds off requests.
// ----------------------------------------------------------------------------
module arp_cache_with_aging
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = ARPC_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_lifetime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= ARPC_LIFETIME_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_lifetime <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_lifetime : '0;

    arpc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lifetime (r_lifetime),
        .i_start    (start),
        .i_req      (i_req),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

// ----- dv/tb_arp_cache_with_aging.sv -----
// ----------------------------------------------------------------------------
// tb_arp_cache_with_aging
// self-checking bench: a behavioural table predicts every response, a monitor
// compares each response word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_arp_cache_with_aging;
    import arpc_pkg::*;

    localparam int N_ENT      = ARPC_ENTRIES;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        req;
    logic        o_done;
    t_rsp        o_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arp_cache_with_aging i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow table, position 0 is the newest insertion
    logic [31:0] lifetime;
    logic        shadow_valid [N_ENT];
    logic [31:0] shadow_ip    [N_ENT];
    logic [47:0] shadow_mac   [N_ENT];
    logic [31:0] shadow_stamp [N_ENT];
    int          shadow_order [N_ENT];
    int          shadow_count;

    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    int     send_gap_pct;
    int     fail_count;
    int     quiet_cycles;
    logic [31:0] ip_pool [16];

    task automatic shadow_drop(input int pos);
        shadow_valid[shadow_order[pos]] = 1'b0;
        for (int p = pos; p + 1 < shadow_count; p++) shadow_order[p] = shadow_order[p + 1];
        shadow_count--;
    endtask

    task automatic predict_response(input t_req r, output t_rsp rsp);
        int pos;
        int s;
        logic [31:0] age;
        rsp = '0;
        if (r.opcode == OP_LOOKUP) begin
            pos = 0;
            while (pos < shadow_count) begin
                s = shadow_order[pos];
                age = r.now_ms - shadow_stamp[s];
                if (age > lifetime) begin
                    shadow_drop(pos);
                end else if (shadow_ip[s] == r.ip_addr) begin
                    rsp.hit = 1'b1;
                    rsp.found_hw_addr = shadow_mac[s];
                    break;
                end else begin
                    pos++;
                end
            end
            return;
        end
        for (pos = 0; pos < shadow_count; pos++) begin
            s = shadow_order[pos];
            if (shadow_ip[s] == r.ip_addr) begin
                shadow_mac[s] = r.hw_addr;
                shadow_stamp[s] = r.now_ms;
                rsp.was_update = 1'b1;
                return;
            end
        end
        if (shadow_count >= N_ENT) begin
            shadow_drop(shadow_count - 1);
            rsp.evicted = 1'b1;
        end
        s = 0;
        for (int i = 0; i < N_ENT; i++) begin
            if (!shadow_valid[i]) begin
                s = i;
                break;
            end
        end
        for (pos = shadow_count; pos > 0; pos--) shadow_order[pos] = shadow_order[pos - 1];
        shadow_order[0] = s;
        shadow_valid[s] = 1'b1;
        shadow_ip[s] = r.ip_addr;
        shadow_mac[s] = r.hw_addr;
        shadow_stamp[s] = r.now_ms;
        shadow_count++;
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor, prediction happens when the request word is taken
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        int   quiet_next;
        if (i_rst_n) begin
            quiet_next = quiet_cycles + 1;
            if (start && !busy) begin
                predict_response(req, want);
                expected_rsps.push_back(want);
                quiet_next = 0;
            end
            if (o_done) begin
                quiet_next = 0;
                got = o_rsp;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response", '0, '0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 48'(got.hit), 48'(want.hit));
                    if (got.found_hw_addr !== want.found_hw_addr)
                        report_mismatch("found_hw_addr", got.found_hw_addr, want.found_hw_addr);
                    if (got.was_update !== want.was_update)
                        report_mismatch("was_update", 48'(got.was_update), 48'(want.was_update));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", 48'(got.evicted), 48'(want.evicted));
                end
            end
            quiet_cycles <= quiet_next;
            if (quiet_next >= WDOG_LIMIT) begin
                $display("** arp_cache_with_aging: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_lifetime(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lifetime = value;
    endtask

    task automatic queue_req(input logic op, input logic [31:0] ip, input logic [47:0] mac,
                             input logic [31:0] now);
        t_req r;
        r.opcode = op;
        r.ip_addr = ip;
        r.hw_addr = mac;
        r.now_ms = now;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge i_clk);
        // idle gap before the next phase
        repeat (300) @(posedge i_clk);
    endtask

    // well-formed traffic: a small pool of addresses, time moving forward
    task automatic random_phase(input int n_items, input int gap_pct, inout logic [31:0] clk_ms,
                                input int step_max);
        send_gap_pct = gap_pct;
        for (int k = 0; k < n_items; k++) begin
            logic [31:0] ip;
            clk_ms += $urandom_range(step_max);
            if ($urandom_range(9) < 8) ip = ip_pool[$urandom_range(15)] + $urandom_range(79);
            else ip = $urandom();
            queue_req(1'($urandom_range(1)), ip, 48'({$urandom(), $urandom()}), clk_ms);
        end
        wait_drained();
    endtask

    initial begin
        logic [31:0] clk_ms;
        i_rst_n = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        lifetime = ARPC_LIFETIME_RESET;
        shadow_count = 0;
        for (int i = 0; i < N_ENT; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_order[i] = 0;
        end
        for (int i = 0; i < 16; i++) ip_pool[i] = $urandom();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset lifetime, extremes, update, expiry, wrap of time
        queue_req(OP_LOOKUP, 32'h0, 48'h0, 32'h0);
        queue_req(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFF0);
        queue_req(OP_ADD, 32'h0, 48'h0, 32'hFFFF_FFF8);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h10);
        queue_req(OP_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 32'h20);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h30);
        queue_req(OP_LOOKUP, 32'h0, 48'h0, 32'd300000 + 32'hFFFF_FFF8);
        queue_req(OP_LOOKUP, 32'h0, 48'h0, 32'd300001 + 32'hFFFF_FFF8);
        queue_req(OP_LOOKUP, 32'h0, 48'h0, 32'h40);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h8000_0000);
        queue_req(OP_ADD, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA, 32'h8000_0000);
        wait_drained();

        // lifetime zero: anything with nonzero age expires; fill past capacity
        write_lifetime(32'd0);
        for (int i = 0; i < N_ENT + 3; i++)
            queue_req(OP_ADD, 32'h0A00_0000 + i, 48'h5555_AAAA_0000 + i, 32'd7);
        queue_req(OP_LOOKUP, 32'h0A00_0005, 48'h0, 32'd7);
        queue_req(OP_LOOKUP, 32'h0A00_0003, 48'h0, 32'd7);
        queue_req(OP_ADD, 32'h0A00_0010, 48'h1, 32'd9);
        queue_req(OP_LOOKUP, 32'h0A00_0042, 48'h0, 32'd8);
        wait_drained();

        clk_ms = 32'hFFFF_0000;
        write_lifetime(32'd500);
        random_phase(300, 7, clk_ms, 40);
        write_lifetime(32'hFFFF_FFFF);
        random_phase(300, 87, clk_ms, 1000);
        write_lifetime(32'd1);
        random_phase(150, 0, clk_ms, 2);
        write_lifetime(32'd3000);
        random_phase(150, 0, clk_ms, 100);

        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("** arp_cache_with_aging: PASSED **");
        end else begin
            $display("** arp_cache_with_aging: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ram.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arp_cache_with_aging.sv
dv/tb_arp_cache_with_aging.sv
